// ===== src/ilsu_pkg.sv =====
package ilsu_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int ACT_W  = 3;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 7;

	localparam logic [ACT_W-1:0] ACT_READ = 3'd0;
	localparam logic [ACT_W-1:0] ACT_HEAD = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TAIL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_AT   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL  = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_INSERT,
		OP_DELETE
	} op_t;

	typedef enum logic [1:0] {
		RD_PTR,
		RD_PTR1,
		RD_PTR2
	} rd_sel_t;

	typedef enum logic {
		WR_VALUE,
		WR_READ
	} wr_sel_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    ptr_inc;
		logic    cnt_inc;
		logic    cnt_dec;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op_new;
		logic ins_last;
		logic del_short;
		logic del_last;
	} dp_stat_t;

endpackage

// ===== src/ilsu_ctrl.sv =====
module ilsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ilsu_pkg::dp_stat_t st,
	output ilsu_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import ilsu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_INS_FIRST,
		S_INS,
		S_DEL_PRIME,
		S_DEL,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = RD_PTR;
		cmd.wr_sel  = WR_READ;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (st.op_new)
						OP_READ:   state_d = S_READ;
						OP_INSERT: state_d = S_INS_FIRST;
						OP_DELETE: state_d = S_DEL_PRIME;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RESP;
			end
			S_INS_FIRST, S_INS: begin
				cmd.rd_en  = 1'b1;
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = (state_q == S_INS_FIRST) ? WR_VALUE : WR_READ;
				if (st.ins_last) begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_INS;
				end
			end
			S_DEL_PRIME: begin
				if (st.del_short) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR1;
					state_d    = S_DEL;
				end
			end
			S_DEL: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_READ;
				if (st.del_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PTR2;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_RESP);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted transaction did not raise busy.");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe while idle.");

endmodule

// ===== src/ilsu_dpath.sv =====
module ilsu_dpath #(
	parameter int CAPACITY = ilsu_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic        [ilsu_pkg::ACT_W-1:0]   action,
	input  logic        [ilsu_pkg::POS_W-1:0]   position,
	input  logic signed [ilsu_pkg::DATA_W-1:0]  value_in,
	input  ilsu_pkg::dp_cmd_t                   cmd,
	output ilsu_pkg::dp_stat_t                  st,
	output logic signed [ilsu_pkg::DATA_W-1:0]  read_value,
	output logic        [ilsu_pkg::ST_W-1:0]    status,
	output logic        [ilsu_pkg::LEN_W-1:0]   length
);
	import ilsu_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_W-1:0] mem [CAPACITY];

	logic [CW-1:0]     count_q;
	logic [XW-1:0]     ptr_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] rdata_q;
	op_t               op_q;
	logic [ST_W-1:0]   status_q;
	logic              miss_q;

	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              full;
	op_t               op_d;
	logic [ST_W-1:0]   status_d;
	logic              miss_d;
	logic [XW-1:0]     tgt_d;
	logic [XW-1:0]     rd_addr_x;
	logic [DATA_W-1:0] wr_data;

	assign pos_x = XW'(position);
	assign cnt_x = XW'(count_q);
	assign full  = (cnt_x >= XW'(CAPACITY));

	always_comb begin
		op_d     = OP_NONE;
		status_d = ST_DONE;
		miss_d   = 1'b0;
		tgt_d    = pos_x;
		unique case (action)
			ACT_READ: begin
				if (pos_x < cnt_x) begin
					op_d = OP_READ;
				end else begin
					status_d = ST_RANGE;
					miss_d   = 1'b1;
				end
			end
			ACT_HEAD: begin
				tgt_d = '0;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d = OP_INSERT;
				end
			end
			ACT_TAIL: begin
				tgt_d = cnt_x;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d = OP_INSERT;
				end
			end
			ACT_AT: begin
				if (pos_x > cnt_x) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d = OP_INSERT;
				end
			end
			ACT_DEL: begin
				if (pos_x >= cnt_x) begin
					status_d = ST_RANGE;
				end else begin
					op_d = OP_DELETE;
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR1: rd_addr_x = ptr_q + XW'(1);
			RD_PTR2: rd_addr_x = ptr_q + XW'(2);
			default: rd_addr_x = ptr_q;
		endcase
	end

	assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr_x[AW-1:0]];
		end
		if (cmd.wr_en) begin
			mem[ptr_q[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ptr_q <= tgt_d;
			val_q <= value_in;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + XW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			op_q     <= OP_NONE;
			status_q <= ST_DONE;
			miss_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				op_q     <= op_d;
				status_q <= status_d;
				miss_q   <= miss_d;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign st.op_new    = op_d;
	assign st.ins_last  = (ptr_q == cnt_x);
	assign st.del_short = ((ptr_q + XW'(1)) == cnt_x);
	assign st.del_last  = ((ptr_q + XW'(2)) == cnt_x);

	assign read_value = (op_q == OP_READ) ? rdata_q : (miss_q ? '1 : '0);
	assign status     = status_q;
	assign length     = LEN_W'(count_q);

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= XW'(CAPACITY))
		else $error("Entry count exceeds capacity.");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + CW'(1))
		else $error("Completed insert did not grow the list by one.");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> ptr_q <= cnt_x)
		else $error("Write beyond the end of the list.");

endmodule

// ===== src/indexed_list_store_unit.sv =====
// Ordered store of up to CAPACITY signed 32-bit entries held in a memory with one read port and
// one write port. A transaction is accepted when start is high and busy is low. It returns exactly
// one result, shown for one cycle while done is high; the receiver cannot stall, so the result
// must be taken in that cycle. A new transaction is not accepted until the previous one has
// returned its result. With n entries held, a head insert goes to position 0 and a tail insert
// to position n. Inserts and deletes move one entry per cycle through the memory's registered
// read port. The store needs no clearing after reset.
module indexed_list_store_unit #(
	parameter int CAPACITY = ilsu_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic        [ilsu_pkg::ACT_W-1:0]   action,
	input  logic        [ilsu_pkg::POS_W-1:0]   position,
	input  logic signed [ilsu_pkg::DATA_W-1:0]  value_in,
	output logic                                done,
	output logic signed [ilsu_pkg::DATA_W-1:0]  read_value,
	output logic        [ilsu_pkg::ST_W-1:0]    status,
	output logic        [ilsu_pkg::LEN_W-1:0]   length
);
	import ilsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	ilsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ilsu_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.action     (action),
		.position   (position),
		.value_in   (value_in),
		.cmd        (cmd),
		.st         (st),
		.read_value (read_value),
		.status     (status),
		.length     (length)
	);

endmodule
